### sv/trom_pkg.sv
// shared types and constants for the tachometer run and overspeed monitor
// used by trom_div and tachometer_run_overspeed_monitor_core
`default_nettype none

package trom_pkg;

    // default width of stored edge timestamps
    localparam int TIME_BITS_DEF = 32;

    // 60000 rpm per ms of period, and the same scaled by 16 for UQ16.4
    localparam logic [15:0] SPEED_NUM    = 16'd60000;
    localparam logic [19:0] SPEED_SCALED = 20'd960000;
    localparam int          SPEED_W      = 20;

    // register reset values
    localparam logic [15:0] RPM_LIMIT_RST    = 16'd3000;
    localparam logic [15:0] START_RPM_RST    = 16'd150;
    localparam logic [7:0]  START_CNT_RST    = 8'd250;
    localparam logic [7:0]  OVER_CNT_RST     = 8'd250;
    localparam logic [15:0] STOP_TIMEOUT_RST = 16'd3000;

    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_RPM_LIMIT    = 3'd0,
        REG_START_RPM    = 3'd1,
        REG_START_CNT    = 3'd2,
        REG_OVER_CNT     = 3'd3,
        REG_STOP_TIMEOUT = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_MUL_START,
        S_MUL_LIMIT,
        S_DIV,
        S_UPDATE,
        S_TIMEOUT,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

### sv/trom_div.sv
// iterative restoring divider: ceil(960000 / divisor), one quotient bit a cycle
// depends on trom_pkg
`default_nettype none

module trom_div (
    input  wire  logic                        i_clk,
    input  wire  logic                        i_rst_n,
    input  wire  logic                        i_start,
    input  wire  logic [trom_pkg::SPEED_W-1:0] i_divisor,
    output logic                              o_done,
    output logic [trom_pkg::SPEED_W-1:0]      o_quot
);
    import trom_pkg::*;

    localparam int CNT_W = $clog2(SPEED_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [SPEED_W-1:0]  r_rem;
    logic [SPEED_W-1:0]  r_quo;
    logic [SPEED_W-1:0]  r_dvd;
    logic [SPEED_W-1:0]  r_dvs;

    logic [SPEED_W:0]    shifted;
    logic [SPEED_W:0]    diff;
    logic                fits;
    logic [SPEED_W:0]    quot_up;

    // shared subtract and compare for one quotient bit
    always_comb begin
        shifted = {r_rem, r_dvd[SPEED_W-1]};
        fits    = shifted >= {1'b0, r_dvs};
        diff    = shifted - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SPEED_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= '0;
            r_dvd <= SPEED_SCALED;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[SPEED_W-1:0] : shifted[SPEED_W-1:0];
            r_quo <= {r_quo[SPEED_W-2:0], fits};
            r_dvd <= {r_dvd[SPEED_W-2:0], 1'b0};
        end
    end

    // round up when a remainder is left
    assign quot_up = {1'b0, r_quo} + {{SPEED_W{1'b0}}, (r_rem != '0)};
    assign o_quot  = quot_up[SPEED_W-1:0];
    assign o_done  = r_done;

endmodule

`default_nettype wire

### sv/tachometer_run_overspeed_monitor_core.sv
// top level of the tachometer run and overspeed monitor: sequencer, registers
// depends on trom_pkg and trom_div
`default_nettype none

// One request is taken at a time; o_stall stays high until its result has been
// taken. A time poll, or an edge without usable timing, passes from S_EDGE through
// S_TIMEOUT to S_OUT, where o_valid is raised. An edge with a usable period also
// passes through S_MUL_START, S_MUL_LIMIT, S_DIV and S_UPDATE: the speed comes
// from a restoring divider that produces one quotient bit per cycle, with the
// round-up folded into its output, and the start and overspeed threshold tests
// share one 16 x 16 multiplier in S_MUL_START and S_MUL_LIMIT. Result-side stalls
// hold the result in S_OUT and delay the next acceptance.
// Speed is reported as ceil(960000 / period) in UQ16.4 rpm, periods wrap modulo
// 2^TIME_BITS, and the configuration registers sit on an APB port at byte
// addresses 0 to 16.
module tachometer_run_overspeed_monitor_core #(
    parameter int TIME_BITS = trom_pkg::TIME_BITS_DEF
) (
    input  wire  logic                        i_clk,
    input  wire  logic                        i_rst_n,
    // input request channel
    input  wire  logic                        i_valid,
    output logic                              o_stall,
    input  wire  logic                        i_edge_req,
    input  wire  logic [31:0]                 i_time_ms,
    // result channel
    output logic                              o_valid,
    input  wire  logic                        i_stall,
    output logic [trom_pkg::SPEED_W-1:0]      o_rpm,
    output logic                              o_machine_on,
    output logic                              o_overspeed_event,
    output logic                              o_started_event,
    output logic                              o_stopped_event,
    // configuration port
    input  wire  logic                        psel,
    input  wire  logic                        penable,
    input  wire  logic                        pwrite,
    input  wire  logic [trom_pkg::ADDR_W-1:0] paddr,
    input  wire  logic [31:0]                 pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import trom_pkg::*;

    localparam int PW = (TIME_BITS > SPEED_W) ? TIME_BITS : SPEED_W;

    t_state r_state;
    t_state n_state;

    // configuration
    logic [15:0] r_rpm_limit;
    logic [15:0] r_start_rpm;
    logic [7:0]  r_start_cnt_lim;
    logic [7:0]  r_over_cnt_lim;
    logic [15:0] r_stop_timeout;

    // monitor state
    logic [TIME_BITS-1:0] r_prev;
    logic [TIME_BITS-1:0] r_latest;
    logic [SPEED_W-1:0]   r_speed;
    logic [7:0]           r_start_cnt;
    logic [7:0]           r_over_cnt;
    logic                 r_running;
    logic                 r_event_fired;
    logic                 r_ev_over;
    logic                 r_ev_start;
    logic                 r_ev_stop;

    logic [SPEED_W-1:0]   n_speed;
    logic [7:0]           n_start_cnt;
    logic [7:0]           n_over_cnt;
    logic                 n_running;
    logic                 n_event_fired;
    logic                 n_ev_over;
    logic                 n_ev_start;
    logic                 n_ev_stop;

    // per-request working registers
    logic                 r_edge;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_period;
    logic                 r_per_big;
    logic                 r_per_ge;
    logic                 r_per_gt;
    logic [31:0]          r_prod;
    logic                 r_above_start;

    logic                 timing_ok;
    logic [TIME_BITS-1:0] period;
    logic [PW-1:0]        per_ext;
    logic [15:0]          mul_a;
    logic [31:0]          mul_p;
    logic                 above_start;
    logic                 above_lim;
    logic                 below_lim;
    logic [TIME_BITS-1:0] since_edge;
    logic                 timeout_hit;
    logic                 cfg_wr;
    logic                 div_start;
    logic                 div_done;
    logic [SPEED_W-1:0]   div_quot;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpm_limit     <= RPM_LIMIT_RST;
            r_start_rpm     <= START_RPM_RST;
            r_start_cnt_lim <= START_CNT_RST;
            r_over_cnt_lim  <= OVER_CNT_RST;
            r_stop_timeout  <= STOP_TIMEOUT_RST;
        end else if (cfg_wr) begin
            case (paddr[ADDR_W-1:2])
                REG_RPM_LIMIT:    r_rpm_limit     <= pwdata[15:0];
                REG_START_RPM:    r_start_rpm     <= pwdata[15:0];
                REG_START_CNT:    r_start_cnt_lim <= pwdata[7:0];
                REG_OVER_CNT:     r_over_cnt_lim  <= pwdata[7:0];
                REG_STOP_TIMEOUT: r_stop_timeout  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_RPM_LIMIT:    prdata = {16'd0, r_rpm_limit};
            REG_START_RPM:    prdata = {16'd0, r_start_rpm};
            REG_START_CNT:    prdata = {24'd0, r_start_cnt_lim};
            REG_OVER_CNT:     prdata = {24'd0, r_over_cnt_lim};
            REG_STOP_TIMEOUT: prdata = {16'd0, r_stop_timeout};
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    assign period    = r_latest - r_prev;
    assign timing_ok = r_edge && (r_latest != '0) && (r_prev != '0) && (r_latest != r_prev);
    assign per_ext   = PW'(r_period);

    // one shared multiplier: start speed first, then the overspeed limit
    assign mul_a = (r_state == S_MUL_START) ? r_start_rpm : r_rpm_limit;
    assign mul_p = mul_a * r_period[15:0];

    assign above_start = (r_start_rpm == '0) ||
                         (!r_per_ge && (32'(SPEED_NUM) > r_prod));
    assign above_lim   = (r_rpm_limit == '0) ||
                         (!r_per_ge && (32'(SPEED_NUM) > r_prod));
    assign below_lim   = (r_rpm_limit != '0) &&
                         (r_per_gt || (32'(SPEED_NUM) < r_prod));

    assign since_edge  = r_now - r_latest;
    assign timeout_hit = (r_latest != '0) && (since_edge >= TIME_BITS'(r_stop_timeout)) &&
                         (r_speed != '0);

    trom_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (per_ext[SPEED_W-1:0]),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_edge <= i_edge_req;
                r_now  <= TIME_BITS'(i_time_ms);
            end
            S_EDGE: begin
                r_period  <= period;
                r_per_big <= PW'(period) > PW'(SPEED_SCALED);
                r_per_ge  <= PW'(period) >= PW'(SPEED_NUM);
                r_per_gt  <= PW'(period) > PW'(SPEED_NUM);
            end
            S_MUL_START: r_prod <= mul_p;
            S_MUL_LIMIT: begin
                r_above_start <= above_start;
                r_prod        <= mul_p;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- monitor state
    always_comb begin
        n_speed       = r_speed;
        n_start_cnt   = r_start_cnt;
        n_over_cnt    = r_over_cnt;
        n_running     = r_running;
        n_event_fired = r_event_fired;
        n_ev_over     = r_ev_over;
        n_ev_start    = r_ev_start;
        n_ev_stop     = r_ev_stop;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_ev_over  = 1'b0;
                    n_ev_start = 1'b0;
                    n_ev_stop  = 1'b0;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_speed = r_per_big ? SPEED_W'(1) : div_quot;
                end
            end
            S_UPDATE: begin
                if (!n_running) begin
                    if (r_above_start && (n_start_cnt < r_start_cnt_lim)) begin
                        n_start_cnt = n_start_cnt + 8'd1;
                    end else if (n_start_cnt >= r_start_cnt_lim) begin
                        n_start_cnt = '0;
                        n_running   = 1'b1;
                        n_ev_start  = 1'b1;
                    end
                end
                // re-arm once speed falls under the limit
                if (n_event_fired && below_lim) begin
                    n_over_cnt    = '0;
                    n_event_fired = 1'b0;
                end
                if (!n_event_fired && n_running) begin
                    if (above_lim) begin
                        if (n_over_cnt < r_over_cnt_lim) begin
                            n_over_cnt = n_over_cnt + 8'd1;
                        end else begin
                            n_event_fired = 1'b1;
                            n_ev_over     = 1'b1;
                            n_over_cnt    = '0;
                        end
                    end else begin
                        n_over_cnt = '0;
                    end
                end
            end
            S_TIMEOUT: begin
                if (timeout_hit) begin
                    n_speed       = '0;
                    n_ev_stop     = r_running;
                    n_running     = 1'b0;
                    n_start_cnt   = '0;
                    n_event_fired = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= '0;
            r_latest      <= '0;
            r_speed       <= '0;
            r_start_cnt   <= '0;
            r_over_cnt    <= '0;
            r_running     <= 1'b0;
            r_event_fired <= 1'b0;
            r_ev_over     <= 1'b0;
            r_ev_start    <= 1'b0;
            r_ev_stop     <= 1'b0;
        end else begin
            // an edge request shifts the timestamps as it is taken
            if ((r_state == S_IDLE) && i_valid && i_edge_req) begin
                r_prev   <= r_latest;
                r_latest <= TIME_BITS'(i_time_ms);
            end
            r_speed       <= n_speed;
            r_start_cnt   <= n_start_cnt;
            r_over_cnt    <= n_over_cnt;
            r_running     <= n_running;
            r_event_fired <= n_event_fired;
            r_ev_over     <= n_ev_over;
            r_ev_start    <= n_ev_start;
            r_ev_stop     <= n_ev_stop;
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_valid) n_state = S_EDGE;
            S_EDGE:      n_state = timing_ok ? S_MUL_START : S_TIMEOUT;
            S_MUL_START: n_state = S_MUL_LIMIT;
            S_MUL_LIMIT: n_state = S_DIV;
            S_DIV:       if (div_done) n_state = S_UPDATE;
            S_UPDATE:    n_state = S_TIMEOUT;
            S_TIMEOUT:   n_state = S_OUT;
            S_OUT:       if (!i_stall) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall   = 1'b1;
        o_valid   = 1'b0;
        div_start = 1'b0;
        case (r_state)
            S_IDLE:      o_stall   = 1'b0;
            S_MUL_START: div_start = 1'b1;
            S_OUT:       o_valid   = 1'b1;
            default: ;
        endcase
    end

    assign o_rpm             = r_speed;
    assign o_machine_on      = r_running;
    assign o_overspeed_event = r_ev_over;
    assign o_started_event   = r_ev_start;
    assign o_stopped_event   = r_ev_stop;

endmodule

`default_nettype wire

### test/tachometer_run_overspeed_monitor_core_test.sv
`timescale 1ns / 1ps
// self-checking testbench for tachometer_run_overspeed_monitor_core: directed
// timing and run/overspeed cases, then random machine runs against a local model
// depends on trom_pkg and the core under test

module tachometer_run_overspeed_monitor_core_test;
    import trom_pkg::*;

    localparam int          PHASE_BUDGET  = 150;
    localparam int          SETTLE_CYCLES = 32;
    localparam int          CYCLE_LIMIT   = 600000;
    localparam logic [2:0]  REG_UNUSED_SLOT = 3'd5;

    typedef enum int {PHASE_RANDOM, PHASE_CEILING, PHASE_FLOOR} t_phase_kind;

    typedef struct packed {
        logic [SPEED_W-1:0] rpm;
        logic               machine_on;
        logic               overspeed_event;
        logic               started_event;
        logic               stopped_event;
    } t_speed_report;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                i_edge_req = 1'b0;
    logic [31:0]         i_time_ms = '0;
    logic                i_stall = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic                o_stall;
    logic                o_valid;
    logic [SPEED_W-1:0]  o_rpm;
    logic                o_machine_on;
    logic                o_overspeed_event;
    logic                o_started_event;
    logic                o_stopped_event;
    logic [31:0]         prdata;
    logic                pready;

    // local copy of the registers and the monitor state
    logic [15:0]         cfg_rpm_limit = RPM_LIMIT_RST;
    logic [15:0]         cfg_start_rpm = START_RPM_RST;
    logic [7:0]          cfg_start_count = START_CNT_RST;
    logic [7:0]          cfg_over_count = OVER_CNT_RST;
    logic [15:0]         cfg_stop_timeout = STOP_TIMEOUT_RST;
    logic [31:0]         prev_edge_ms = '0;
    logic [31:0]         last_edge_ms = '0;
    logic [SPEED_W-1:0]  speed_q4 = '0;
    logic [7:0]          start_count = '0;
    logic [7:0]          over_count = '0;
    logic                running = 1'b0;
    logic                over_fired = 1'b0;

    t_speed_report       predicted_reports[$];
    t_speed_report       oldest_report;
    logic [31:0]         stream_ms = '0;
    bit                  idle_on = 1'b1;
    int                  hold_left = 0;
    int                  cycle_count = 0;
    int                  requests_sent = 0;
    int                  edges_sent = 0;
    int                  starts_seen = 0;
    int                  overspeeds_seen = 0;
    int                  stops_seen = 0;
    int                  reports_checked = 0;
    int                  mismatches = 0;

    tachometer_run_overspeed_monitor_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_edge_req        (i_edge_req),
        .i_time_ms         (i_time_ms),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_rpm             (o_rpm),
        .o_machine_on      (o_machine_on),
        .o_overspeed_event (o_overspeed_event),
        .o_started_event   (o_started_event),
        .o_stopped_event   (o_stopped_event),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout with %0d results outstanding", $time, predicted_reports.size());
        $display("tachometer_run_overspeed_monitor_core verification failed");
        $finish;
    end

    // exact test of 60000/period > limit
    function automatic bit faster_than(input logic [31:0] period, input logic [15:0] limit);
        if (limit == 0) return 1'b1;
        if (period >= SPEED_NUM) return 1'b0;
        return 64'(SPEED_NUM) > 64'(limit) * 64'(period);
    endfunction

    // exact test of 60000/period < limit
    function automatic bit slower_than(input logic [31:0] period, input logic [15:0] limit);
        if (limit == 0) return 1'b0;
        if (period > SPEED_NUM) return 1'b1;
        return 64'(SPEED_NUM) < 64'(limit) * 64'(period);
    endfunction

    function automatic t_speed_report advance_speed_model(input logic is_edge,
                                                          input logic [31:0] now);
        t_speed_report report;
        logic [31:0]   period;
        logic [31:0]   since_edge;
        logic [63:0]   quotient;
        report = '0;
        if (is_edge) begin
            prev_edge_ms = last_edge_ms;
            last_edge_ms = now;
            if (last_edge_ms != 0 && prev_edge_ms != 0 && last_edge_ms != prev_edge_ms) begin
                period = last_edge_ms - prev_edge_ms;
                quotient = 64'(SPEED_SCALED) / 64'(period);
                if (quotient * 64'(period) != 64'(SPEED_SCALED)) quotient = quotient + 64'd1;
                speed_q4 = quotient[SPEED_W-1:0];
                if (!running) begin
                    if (faster_than(period, cfg_start_rpm) && start_count < cfg_start_count) begin
                        start_count = start_count + 8'd1;
                    end else if (start_count >= cfg_start_count) begin
                        start_count = '0;
                        running = 1'b1;
                        report.started_event = 1'b1;
                    end
                end
                // a fired event re-arms once the speed falls under the limit
                if (over_fired && slower_than(period, cfg_rpm_limit)) begin
                    over_count = '0;
                    over_fired = 1'b0;
                end
                if (!over_fired && running) begin
                    if (faster_than(period, cfg_rpm_limit)) begin
                        if (over_count < cfg_over_count) begin
                            over_count = over_count + 8'd1;
                        end else begin
                            over_fired = 1'b1;
                            report.overspeed_event = 1'b1;
                            over_count = '0;
                        end
                    end else begin
                        over_count = '0;
                    end
                end
            end
        end
        since_edge = now - last_edge_ms;
        if (last_edge_ms != 0 && since_edge >= {16'h0, cfg_stop_timeout} && speed_q4 != 0) begin
            speed_q4 = '0;
            if (running) report.stopped_event = 1'b1;
            start_count = '0;
            running = 1'b0;
            over_fired = 1'b0;
        end
        report.rpm = speed_q4;
        report.machine_on = running;
        return report;
    endfunction

    function automatic void compare_field(input string name, input logic [SPEED_W-1:0] want,
                                          input logic [SPEED_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (predicted_reports.size() == 0) begin
                $display("%0t: result with nothing outstanding, expected none actual rpm %0d",
                         $time, o_rpm);
                mismatches++;
            end else begin
                oldest_report = predicted_reports.pop_front();
                compare_field("rpm", oldest_report.rpm, o_rpm);
                compare_field("machine_on", oldest_report.machine_on, o_machine_on);
                compare_field("overspeed_event", oldest_report.overspeed_event,
                              o_overspeed_event);
                compare_field("started_event", oldest_report.started_event, o_started_event);
                compare_field("stopped_event", oldest_report.stopped_event, o_stopped_event);
                reports_checked++;
            end
        end
    end

    // result side back-pressure in bursts
    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_stall <= 1'b1;
            hold_left <= $urandom_range(0, 8);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_request(input logic is_edge, input logic [31:0] stamp);
        t_speed_report predicted;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_edge_req <= is_edge;
        i_time_ms <= stamp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = advance_speed_model(is_edge, stamp);
        predicted_reports.push_back(predicted);
        requests_sent++;
        if (is_edge) edges_sent++;
        if (predicted.started_event) starts_seen++;
        if (predicted.overspeed_event) overspeeds_seen++;
        if (predicted.stopped_event) stops_seen++;
    endtask

    task automatic drain_reports();
        i_valid <= 1'b0;
        while (predicted_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_register(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RPM_LIMIT:    cfg_rpm_limit = value[15:0];
            REG_START_RPM:    cfg_start_rpm = value[15:0];
            REG_START_CNT:    cfg_start_count = value[7:0];
            REG_OVER_CNT:     cfg_over_count = value[7:0];
            REG_STOP_TIMEOUT: cfg_stop_timeout = value[15:0];
            default: ;
        endcase
    endtask

    task automatic feed_edge(input logic [31:0] period);
        stream_ms = stream_ms + period;
        send_request(1'b1, stream_ms);
    endtask

    task automatic feed_poll(input logic [31:0] delay);
        send_request(1'b0, stream_ms + delay);
    endtask

    function automatic logic [31:0] period_faster_than(input logic [15:0] limit);
        int unsigned longest;
        if (limit == 0) return $urandom_range(1, 2000);
        longest = (SPEED_NUM - 1) / limit;
        if (longest == 0) return 32'd1;
        if ($urandom_range(0, 4) == 0) return longest;
        return $urandom_range(1, longest);
    endfunction

    function automatic logic [31:0] period_slower_than(input logic [15:0] limit);
        int unsigned shortest;
        if (limit == 0) return $urandom_range(1, 2000);
        shortest = SPEED_NUM / limit + 1;
        if ($urandom_range(0, 4) == 0) return shortest;
        return $urandom_range(shortest, 3 * shortest);
    endfunction

    task automatic inject_noise();
        case ($urandom_range(0, 3))
            0: send_request(1'b1, 32'd0);
            1: send_request(1'b1, stream_ms);  // same stamp as the last edge
            2: send_request(1'($urandom_range(0, 1)), $urandom());
            default: feed_poll($urandom());
        endcase
    endtask

    // one spin-up, cruise with overspeed bursts, then usually a stop by timeout
    task automatic machine_run();
        int spin_edges;
        int burst;
        spin_edges = cfg_start_count + $urandom_range(1, 4);
        if (spin_edges > 40) spin_edges = 40;
        feed_edge($urandom_range(1, 100000));
        repeat (spin_edges) begin
            if ($urandom_range(0, 7) == 0) feed_edge(period_slower_than(cfg_start_rpm));
            else feed_edge(period_faster_than(cfg_start_rpm));
            if ($urandom_range(0, 7) == 0) feed_poll($urandom_range(0, cfg_stop_timeout - 1));
        end
        repeat ($urandom_range(3, 10)) begin
            case ($urandom_range(0, 5))
                0, 1, 2: begin
                    burst = cfg_over_count + $urandom_range(1, 3);
                    if (burst > 30) burst = 30;
                    repeat (burst) feed_edge(period_faster_than(cfg_rpm_limit));
                end
                3: repeat ($urandom_range(1, 4)) feed_edge(period_slower_than(cfg_rpm_limit));
                4: feed_edge(cfg_rpm_limit == 16'd0 ? 32'd1 : 32'(SPEED_NUM / cfg_rpm_limit));
                default: inject_noise();
            endcase
            if ($urandom_range(0, 5) == 0) feed_poll($urandom_range(0, cfg_stop_timeout - 1));
        end
        if ($urandom_range(0, 3) != 0) begin
            feed_poll(cfg_stop_timeout + $urandom_range(0, 2));
            feed_poll(cfg_stop_timeout + $urandom_range(3, 50));
        end
    endtask

    task automatic traffic_phase(input t_phase_kind kind);
        int           stop_at;
        logic [15:0]  limit;
        drain_reports();
        case (kind)
            PHASE_CEILING: begin
                program_register(REG_RPM_LIMIT, 32'h0000_FFFF);
                program_register(REG_START_RPM, 32'h0000_FFFF);
                program_register(REG_START_CNT, 32'h0000_00FF);
                program_register(REG_OVER_CNT, 32'h0000_00FF);
                program_register(REG_STOP_TIMEOUT, 32'h0000_FFFF);
            end
            PHASE_FLOOR: begin
                program_register(REG_RPM_LIMIT, 32'd0);
                program_register(REG_START_RPM, 32'd0);
                program_register(REG_START_CNT, 32'd0);
                program_register(REG_OVER_CNT, 32'd0);
                program_register(REG_STOP_TIMEOUT, 32'd1);
            end
            default: begin
                // junk above each register's width must be dropped
                if ($urandom_range(0, 7) == 0) limit = 16'($urandom());
                else limit = 16'(SPEED_NUM / $urandom_range(2, 60));
                program_register(REG_RPM_LIMIT, {16'($urandom()), limit});
                program_register(REG_START_RPM,
                                 {16'($urandom()), 16'(limit / $urandom_range(2, 20))});
                if ($urandom_range(0, 5) == 0)
                    program_register(REG_START_CNT, {24'($urandom()), 8'($urandom_range(16, 35))});
                else
                    program_register(REG_START_CNT, {24'($urandom()), 8'($urandom_range(0, 15))});
                program_register(REG_OVER_CNT, {24'($urandom()), 8'($urandom_range(0, 10))});
                program_register(REG_STOP_TIMEOUT,
                                 {16'($urandom()), 16'($urandom_range(200, 4000))});
            end
        endcase
        if ($urandom_range(0, 2) == 0) stream_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
        else stream_ms = $urandom();
        stop_at = requests_sent + PHASE_BUDGET;
        while (requests_sent < stop_at) begin
            machine_run();
            if ($urandom_range(0, 3) == 0) inject_noise();
        end
    endtask

    // reset register values: invalid stamps, period extremes, wrap, timeout edge
    task automatic test_timing_cases();
        send_request(1'b0, 32'd0);
        send_request(1'b1, 32'd0);
        send_request(1'b1, 32'd100);
        send_request(1'b1, 32'd100);
        send_request(1'b1, 32'd101);
        send_request(1'b1, 32'd60101);
        send_request(1'b1, 32'd120102);
        send_request(1'b1, 32'hFFFF_FFFF);
        send_request(1'b1, 32'h0000_0013);
        send_request(1'b0, 32'h0000_0013 + 32'd2999);
        send_request(1'b0, 32'h0000_0013 + 32'd3000);
        send_request(1'b0, 32'h0000_0013 + 32'd3000);
    endtask

    // immediate start, overspeed fire, hold at the exact limit, re-arm, stops
    task automatic test_run_cases();
        drain_reports();
        program_register(REG_START_CNT, 32'd0);
        program_register(REG_OVER_CNT, 32'd1);
        program_register(REG_START_RPM, 32'd0);
        program_register(REG_STOP_TIMEOUT, 32'd1);
        program_register(REG_UNUSED_SLOT, 32'hFFFF_FFFF);
        program_register(REG_RPM_LIMIT, 32'hABCD_0BB8);
        send_request(1'b1, 32'd1000);
        send_request(1'b1, 32'd1010);
        send_request(1'b1, 32'd1020);
        send_request(1'b1, 32'd1030);
        send_request(1'b1, 32'd1050);
        send_request(1'b1, 32'd1080);
        send_request(1'b1, 32'd1090);
        send_request(1'b0, 32'd1090);
        send_request(1'b0, 32'd1091);
        // a zero timeout stops the machine on the same request that starts it
        drain_reports();
        program_register(REG_STOP_TIMEOUT, 32'd0);
        send_request(1'b1, 32'd2000);
        send_request(1'b0, 32'd2000);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 7; phase++) begin
            idle_on = (phase % 3 != 2);
            case (phase)
                0: traffic_phase(PHASE_CEILING);
                1: traffic_phase(PHASE_FLOOR);
                default: traffic_phase(PHASE_RANDOM);
            endcase
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        traffic_phase(PHASE_RANDOM);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_timing_cases();
        test_run_cases();
        test_random_traffic();
        test_back_to_back();
        drain_reports();
        $display("checked %0d results from %0d requests (%0d edges)",
                 reports_checked, requests_sent, edges_sent);
        $display("machine starts %0d, overspeed events %0d, timeout stops %0d",
                 starts_seen, overspeeds_seen, stops_seen);
        if (mismatches == 0) begin
            $display("tachometer_run_overspeed_monitor_core verification clean");
        end else begin
            $display("tachometer_run_overspeed_monitor_core verification failed");
        end
        $finish;
    end

endmodule
